[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/rsfir_pkg.sv]
// constants, types and helpers of the rational resampling fir
`default_nettype none
package rsfir_pkg;

  // sizes of the block
  localparam int MAX_TAPS    = 128;
  localparam int MAX_FACTOR  = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int FRAC_BITS   = COEF_BITS - 1;

  // fixed field widths
  localparam int FCFG_W    = 5;
  localparam int TAPCNT_W  = 8;
  localparam int REQ_W     = 2;
  localparam int TAPIDX_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 8;

  // derived widths
  localparam int TAP_AW = $clog2(MAX_TAPS);
  localparam int NT_W   = $clog2(MAX_TAPS + 1);
  localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
  localparam int PH_W   = $clog2(MAX_FACTOR);
  localparam int TW     = $clog2(MAX_TAPS + MAX_FACTOR);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + TAP_AW;
  localparam int SCL_W  = ACC_W + FAC_W + 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_TAP    = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_CLEAR  = REQ_W'(2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS = CFG_IDX_W'(2);

  // sequencer to mac controls
  typedef struct packed {
    logic clear;
    logic load;
    logic scale;
  } mac_ctl_t;

  // mac status and rounded result
  typedef struct packed {
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          saturated;
  } mac_st_t;

  // factor register to working factor, zero acts as one
  function automatic logic [FAC_W-1:0] clamp_factor(logic [FCFG_W-1:0] v);
    if (v == '0) return FAC_W'(1);
    if (int'(v) > MAX_FACTOR) return FAC_W'(MAX_FACTOR);
    return FAC_W'(v);
  endfunction

  // tap count register to working tap count
  function automatic logic [NT_W-1:0] clamp_taps(logic [TAPCNT_W-1:0] v);
    if (int'(v) > MAX_TAPS) return NT_W'(MAX_TAPS);
    return NT_W'(v);
  endfunction

endpackage
`default_nettype wire

[rtl/rsfir_if.sv]
// handshake channels of the rational resampling fir
`default_nettype none

// request channel
interface rsfir_req_if;
  import rsfir_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [REQ_W-1:0]              req_type;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [TAPIDX_W-1:0]           tap_index;
  logic signed [COEF_BITS-1:0]   tap_value;
  modport source (output valid, req_type, sample, tap_index, tap_value, input ready);
  modport sink (input valid, req_type, sample, tap_index, tap_value, output ready);
endinterface

// result channel
interface rsfir_res_if;
  import rsfir_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          saturated;
  logic                          last;
  modport source (output valid, out_sample, saturated, last, input ready);
  modport sink (input valid, out_sample, saturated, last, output ready);
endinterface

// register write channel
interface rsfir_cfg_if;
  import rsfir_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/rsfir_mac.sv]
// shared multiply-accumulate, gain, rounding and saturation
`default_nettype none
module rsfir_mac import rsfir_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mac_ctl_t                      ctl,
  input  wire logic signed [COEF_BITS-1:0]   coef,
  input  wire logic signed [SAMPLE_BITS-1:0] smp,
  input  wire logic [FAC_W-1:0]              gain,
  output mac_st_t                            st
);

  localparam int V_W = SCL_W - FRAC_BITS;
  localparam logic signed [SCL_W-1:0] HALF = SCL_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [V_W-1:0] SMAX = V_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [V_W-1:0] SMIN = -SMAX - V_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic                     mul_v;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [FAC_W:0]    gain_s;
  logic signed [SCL_W-1:0]  rsum;
  logic signed [V_W-1:0]    vq;
  logic                     hi_clip;
  logic                     lo_clip;

  assign gain_s = signed'({1'b0, gain});

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= coef * smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= ctl.load;
    end
  end

  // accumulate and apply the interpolation gain
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (ctl.scale) begin
      scaled <= acc * gain_s;
    end
  end

  // round half up, drop fraction bits, clip
  assign rsum    = scaled + HALF;
  assign vq      = rsum[SCL_W-1:FRAC_BITS];
  assign hi_clip = vq > SMAX;
  assign lo_clip = vq < SMIN;

  always_comb begin
    st.busy      = ctl.load | mul_v;
    st.saturated = hi_clip | lo_clip;
    if (hi_clip) begin
      st.out_sample = SMAX[SAMPLE_BITS-1:0];
    end else if (lo_clip) begin
      st.out_sample = SMIN[SAMPLE_BITS-1:0];
    end else begin
      st.out_sample = vq[SAMPLE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/rational_resampling_fir.sv]
// top level of the rational resampling fir
//
//   channel  role    payload
//   req      sink    req_type, sample, tap_index, tap_value
//   res      source  out_sample, saturated, last
//   cfg      sink    index, data (up_factor, down_factor, tap_count)
//
// a tap write or clear is taken in the idle state; a sample steps through its L
// positions, and each one kept by the decimation phase issues n = ceil((nt - r) / L)
// products of result r, then drains, scales and emits, with the single shared
// mac reading one coefficient and one history word per cycle while issuing.
// rst is synchronous and clears history valid bits, the write pointer and phase at once.
// a full result register stalls only the finishing step of the next result.
`default_nettype none
`include "assert_macros.svh"
module rational_resampling_fir import rsfir_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  rsfir_req_if.sink   req,
  rsfir_res_if.source res,
  rsfir_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_ISSUE,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [FCFG_W-1:0]   up_factor;
  logic [FCFG_W-1:0]   down_factor;
  logic [TAPCNT_W-1:0] tap_count;

  // stream state and working values
  logic [TAP_AW-1:0]   wp;
  logic [PH_W-1:0]     phase;
  logic [MAX_TAPS-1:0] hvalid;
  logic [FAC_W-1:0]    up_l;
  logic [FAC_W-1:0]    down_m;
  logic [NT_W-1:0]     nt;
  logic [FAC_W-1:0]    r;
  logic [TW-1:0]       t;
  logic [TAP_AW-1:0]   hp;
  logic                last_pos;
  logic                rd_v;
  logic                hv_q;

  // memories and their read registers
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;

  // result register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          saturated;
  logic                          last;

  logic [TAP_AW-1:0] wp_inc;
  logic [FAC_W-1:0]  ph1;
  logic [PH_W-1:0]   phase_inc;
  logic              r_end;
  logic              req_acc;
  logic              take_sample;
  logic              take_tap;
  logic              take_clear;
  logic              issue;
  logic              emit_go;
  mac_ctl_t          mac_ctl;
  mac_st_t           mac_st;

  assign req.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign req_acc     = req.valid && req.ready;
  assign take_sample = req_acc && (req.req_type == REQ_SAMPLE);
  assign take_tap    = req_acc && (req.req_type == REQ_TAP);
  assign take_clear  = req_acc && (req.req_type == REQ_CLEAR);

  assign res.valid      = out_valid;
  assign res.out_sample = out_sample;
  assign res.saturated  = saturated;
  assign res.last       = last;

  // position stepping
  assign wp_inc    = wp + TAP_AW'(1);
  assign ph1       = FAC_W'(phase) + FAC_W'(1);
  assign phase_inc = (ph1 >= down_m) ? '0 : PH_W'(ph1);
  assign r_end     = (r + FAC_W'(1)) >= up_l;
  assign issue     = (state == ST_ISSUE) && (t < TW'(nt));
  assign emit_go   = (state == ST_EMIT) && (!out_valid || res.ready);

  // mac controls
  assign mac_ctl.clear = (state == ST_POS) && (phase == '0);
  assign mac_ctl.load  = rd_v;
  assign mac_ctl.scale = (state == ST_SCALE);

  rsfir_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (coef_q),
    .smp  (hv_q ? hist_q : '0),
    .gain (up_l),
    .st   (mac_st)
  );

  // coefficient memory
  always_ff @(posedge clk) begin
    if (take_tap) begin
      coef_mem[TAP_AW'(req.tap_index)] <= req.tap_value;
    end
    if (state == ST_ISSUE) begin
      coef_q <= coef_mem[t[TAP_AW-1:0]];
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (take_sample) begin
      hist_mem[wp_inc] <= req.sample;
    end
    if (state == ST_ISSUE) begin
      hist_q <= hist_mem[hp];
    end
  end

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      up_factor   <= FCFG_W'(1);
      down_factor <= FCFG_W'(1);
      tap_count   <= TAPCNT_W'(1);
      wp          <= '0;
      phase       <= '0;
      hvalid      <= '0;
      rd_v        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // register writes
      if (cfg.valid) begin
        case (cfg.index)
          CFG_UP:   up_factor   <= cfg.data[FCFG_W-1:0];
          CFG_DOWN: down_factor <= cfg.data[FCFG_W-1:0];
          CFG_TAPS: tap_count   <= cfg.data[TAPCNT_W-1:0];
          default: ;
        endcase
      end

      rd_v <= issue;

      // result register fill and drain
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (take_sample) begin
            wp             <= wp_inc;
            hvalid[wp_inc] <= 1'b1;
            up_l           <= clamp_factor(up_factor);
            down_m         <= clamp_factor(down_factor);
            nt             <= clamp_taps(tap_count);
            r              <= '0;
            state          <= ST_POS;
          end else if (take_clear) begin
            hvalid <= '0;
            wp     <= '0;
            phase  <= '0;
          end
        end
        ST_POS: begin
          if (phase == '0) begin
            t        <= TW'(r);
            hp       <= wp;
            last_pos <= ({1'b0, r} + {1'b0, down_m}) >= {1'b0, up_l};
            state    <= ST_ISSUE;
          end else begin
            phase <= phase_inc;
            if (r_end) begin
              state <= ST_IDLE;
            end else begin
              r <= r + FAC_W'(1);
            end
          end
        end
        ST_ISSUE: begin
          if (issue) begin
            hv_q <= hvalid[hp];
            t    <= t + TW'(up_l);
            hp   <= hp - TAP_AW'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!mac_st.busy) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_sample <= mac_st.out_sample;
            saturated  <= mac_st.saturated;
            last       <= last_pos;
            phase      <= phase_inc;
            if (r_end) begin
              state <= ST_IDLE;
            end else begin
              r     <= r + FAC_W'(1);
              state <= ST_POS;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_CLK(a_hist_marked, clk, rst, take_sample |=> hvalid[wp], "history entry not marked")
  `ASSERT_CLK(a_clear_done, clk, rst, take_clear |=> (wp == '0 && phase == '0), "clear incomplete")
  `ASSERT_NEVER(a_scale_busy, clk, rst, state == ST_SCALE && mac_st.busy, "scale with mac busy")

endmodule
`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench of the rational resampling fir with a shadow filter model
`timescale 1ns / 100ps
module tb_top;
  import rsfir_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 20;
  localparam int PRESS_PHASE  = 4;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_WINDOW  = 100;

  typedef struct packed {
    logic [REQ_W-1:0]              req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [TAPIDX_W-1:0]           tap_index;
    logic signed [COEF_BITS-1:0]   tap_value;
  } fir_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          saturated;
    logic                          last;
  } fir_out_t;

  logic clk;
  logic rst;

  rsfir_req_if req_ch ();
  rsfir_res_if res_ch ();
  rsfir_cfg_if cfg_ch ();

  rational_resampling_fir dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // requests waiting for the driver and outputs waiting for the dut
  fir_req_t req_pending[$];
  fir_out_t out_expected[$];

  // shadow copy of the filter state and registers
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [TAP_AW-1:0]             hist_wp = '0;
  int                            dec_phase = 0;
  logic [FCFG_W-1:0]             up_reg = FCFG_W'(1);
  logic [FCFG_W-1:0]             down_reg = FCFG_W'(1);
  logic [TAPCNT_W-1:0]           ntap_reg = TAPCNT_W'(1);

  int mismatch_cnt = 0;
  bit req_taken = 1'b0;
  bit no_idle = 1'b0;
  bit hold_pending = 1'b0;
  int hold_cnt = 0;
  int src_gap = 0, src_rate = 0, src_win = 0;
  int snk_gap = 0, snk_rate = 0, snk_win = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // factor register to the factor in use
  function automatic int working_factor(logic [FCFG_W-1:0] f);
    if (f == '0) return 1;
    if (int'(f) > MAX_FACTOR) return MAX_FACTOR;
    return int'(f);
  endfunction

  // apply one accepted item to the shadow filter, queue the outputs it causes
  task automatic filter_request(input fir_req_t rq);
    int       lf, mf, nt, k;
    longint   acc, hi_lim;
    fir_out_t o;
    bit       produced;
    produced = 1'b0;
    hi_lim = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    case (rq.req_type)
      REQ_TAP: coef_mem[rq.tap_index] = rq.tap_value;
      REQ_CLEAR: begin
        foreach (hist_mem[i]) hist_mem[i] = '0;
        hist_wp = '0;
        dec_phase = 0;
      end
      REQ_SAMPLE: begin
        lf = working_factor(up_reg);
        mf = working_factor(down_reg);
        nt = (int'(ntap_reg) > MAX_TAPS) ? MAX_TAPS : int'(ntap_reg);
        hist_wp = hist_wp + 1'b1;
        hist_mem[hist_wp] = rq.sample;
        // walk the zero-stuffed positions, keep those at phase zero
        for (int r = 0; r < lf; r++) begin
          if (dec_phase == 0) begin
            acc = 0;
            k = 0;
            for (int t = r; t < nt; t += lf) begin
              acc += longint'(coef_mem[t]) * longint'(hist_mem[TAP_AW'(hist_wp - k)]);
              k++;
            end
            // gain, round half up, saturate
            acc = acc * lf + (longint'(1) <<< (FRAC_BITS - 1));
            acc = acc >>> FRAC_BITS;
            o.saturated = (acc > hi_lim) || (acc < -hi_lim - 1);
            if (acc > hi_lim) acc = hi_lim;
            if (acc < -hi_lim - 1) acc = -hi_lim - 1;
            o.out_sample = SAMPLE_BITS'(acc);
            o.last = 1'b0;
            out_expected.push_back(o);
            produced = 1'b1;
          end
          dec_phase = (dec_phase + 1 >= mf) ? 0 : dec_phase + 1;
        end
        if (produced) begin
          o = out_expected.pop_back();
          o.last = 1'b1;
          out_expected.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // monitor: check outputs, track register writes and accepted items
  always @(posedge clk) begin
    fir_out_t got, want;
    fir_req_t rq;
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.out_sample = res_ch.out_sample;
        got.saturated = res_ch.saturated;
        got.last = res_ch.last;
        if (out_expected.size() == 0) begin
          note_mismatch($sformatf("unexpected output sample=%0d sat=%0b last=%0b",
                                  got.out_sample, got.saturated, got.last));
        end else begin
          want = out_expected.pop_front();
          if (got.out_sample !== want.out_sample || got.saturated !== want.saturated ||
              got.last !== want.last)
            note_mismatch($sformatf(
                "sample exp %0d got %0d, sat exp %0b got %0b, last exp %0b got %0b",
                want.out_sample, got.out_sample, want.saturated,
                got.saturated, want.last, got.last));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_UP:   up_reg = cfg_ch.data[FCFG_W-1:0];
          CFG_DOWN: down_reg = cfg_ch.data[FCFG_W-1:0];
          CFG_TAPS: ntap_reg = cfg_ch.data[TAPCNT_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        rq.req_type = req_ch.req_type;
        rq.sample = req_ch.sample;
        rq.tap_index = req_ch.tap_index;
        rq.tap_value = req_ch.tap_value;
        filter_request(rq);
      end
    end
  end

  // driver: present pending items with random idle bursts
  always @(negedge clk) begin
    logic     nv;
    fir_req_t rq;
    nv = req_ch.valid;
    if (src_win == 0) begin
      src_win = IDLE_WINDOW;
      src_rate = $urandom_range(0, 3);
    end
    src_win--;
    if (rst) begin
      nv = 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      nv = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (req_pending.size() > 0) begin
        if (!no_idle && $urandom_range(0, 15) < src_rate) begin
          src_gap = $urandom_range(0, 15);
        end else begin
          rq = req_pending.pop_front();
          req_ch.req_type <= rq.req_type;
          req_ch.sample <= rq.sample;
          req_ch.tap_index <= rq.tap_index;
          req_ch.tap_value <= rq.tap_value;
          nv = 1'b1;
        end
      end
    end
    req_ch.valid <= nv;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (snk_win == 0) begin
      snk_win = IDLE_WINDOW;
      snk_rate = $urandom_range(0, 3);
    end
    snk_win--;
    if (hold_pending) begin
      hold_cnt = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      nr = 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      nr = 1'b0;
    end else if (!no_idle && $urandom_range(0, 15) < snk_rate) begin
      snk_gap = $urandom_range(0, 15);
      nr = 1'b0;
    end
    res_ch.ready <= nr;
  end

  // stimulus helpers
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    logic [31:0] w;
    w = $urandom;
    return $signed(w[SAMPLE_BITS-1:0]) >>> $urandom_range(0, SAMPLE_BITS - 1);
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rand_tap();
    logic [31:0] w;
    w = $urandom;
    return $signed(w[COEF_BITS-1:0]) >>> $urandom_range(0, 14);
  endfunction

  function automatic void queue_req(input logic [REQ_W-1:0] kind,
                                    input logic signed [SAMPLE_BITS-1:0] s,
                                    input logic [TAPIDX_W-1:0] idx,
                                    input logic signed [COEF_BITS-1:0] cv);
    fir_req_t rq;
    rq.req_type = kind;
    rq.sample = s;
    rq.tap_index = idx;
    rq.tap_value = cv;
    req_pending.push_back(rq);
  endfunction

  function automatic void queue_sample(input logic signed [SAMPLE_BITS-1:0] s);
    queue_req(REQ_SAMPLE, s, TAPIDX_W'($urandom), COEF_BITS'($urandom));
  endfunction

  function automatic void queue_tap(input logic [TAPIDX_W-1:0] idx,
                                    input logic signed [COEF_BITS-1:0] cv);
    queue_req(REQ_TAP, SAMPLE_BITS'($urandom), idx, cv);
  endfunction

  // random mix of samples, tap writes, clears and unused requests
  function automatic void queue_random(input int n);
    int cnt, pick;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        queue_sample(rand_sample());
        cnt++;
      end else if (pick < 88) begin
        queue_tap(TAPIDX_W'($urandom), rand_tap());
        cnt++;
      end else if (pick < 94) begin
        queue_req(REQ_CLEAR, SAMPLE_BITS'($urandom), TAPIDX_W'($urandom),
                  COEF_BITS'($urandom));
        cnt++;
      end else begin
        queue_req(REQ_UNUSED, SAMPLE_BITS'($urandom), TAPIDX_W'($urandom),
                  COEF_BITS'($urandom));
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // all items taken, all outputs seen, then let the block settle
  task automatic wait_idle();
    while (req_pending.size() != 0 || req_ch.valid || out_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    int up_v, dn_v, nt_v;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SAMPLE;
    req_ch.sample = '0;
    req_ch.tap_index = '0;
    req_ch.tap_value = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_UP;
    cfg_ch.data = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // load every tap so no unwritten coefficient is ever read
    for (int i = 0; i < MAX_TAPS; i++) queue_tap(TAPIDX_W'(i), rand_tap());

    // extremes at unit factors and a single tap
    queue_tap('0, COEF_BITS'(131071));
    queue_sample(SAMPLE_BITS'(8388607));
    queue_sample(SAMPLE_BITS'(-8388608));
    queue_sample('0);
    queue_sample(SAMPLE_BITS'(-1));
    queue_tap('0, COEF_BITS'(-131072));
    queue_sample(SAMPLE_BITS'(-8388608));
    queue_sample(SAMPLE_BITS'(8388607));
    // half-way rounding ties
    queue_tap('0, COEF_BITS'(65536));
    queue_sample(SAMPLE_BITS'(1));
    queue_sample(SAMPLE_BITS'(-1));
    queue_sample(SAMPLE_BITS'(3));
    queue_tap(TAPIDX_W'(127), COEF_BITS'(131071));
    queue_tap(TAPIDX_W'(127), COEF_BITS'(-131072));
    queue_req(REQ_CLEAR, '0, '0, '0);
    queue_req(REQ_UNUSED, SAMPLE_BITS'($urandom), TAPIDX_W'($urandom), COEF_BITS'($urandom));
    queue_sample(SAMPLE_BITS'(1234));
    wait_idle();

    // zero factors act as one, zero tap count gives zero-valued outputs
    write_reg(CFG_UP, 8'hE0);
    write_reg(CFG_DOWN, 8'hA0);
    write_reg(CFG_TAPS, 8'h00);
    queue_sample(SAMPLE_BITS'(8388607));
    queue_sample(SAMPLE_BITS'(-5000));
    wait_idle();

    // oversized factors and tap count are clamped
    write_reg(CFG_UP, 8'd31);
    write_reg(CFG_DOWN, 8'd31);
    write_reg(CFG_TAPS, 8'd255);
    queue_sample(SAMPLE_BITS'(-8388608));
    queue_sample(SAMPLE_BITS'(8388607));
    wait_idle();

    // most outputs per sample
    write_reg(CFG_UP, 8'd16);
    write_reg(CFG_DOWN, 8'd1);
    write_reg(CFG_TAPS, 8'd128);
    queue_sample(rand_sample());
    queue_sample(SAMPLE_BITS'(-8388608));
    wait_idle();

    // lowering the decimation factor below the current phase
    write_reg(CFG_UP, 8'd3);
    write_reg(CFG_DOWN, 8'd7);
    write_reg(CFG_TAPS, 8'd10);
    queue_sample(rand_sample());
    wait_idle();
    write_reg(CFG_DOWN, 8'd2);
    queue_sample(rand_sample());
    queue_sample(rand_sample());
    wait_idle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) no_idle = 1'b1;
      if (ph == PRESS_PHASE) begin
        up_v = 4;
        dn_v = 3;
        nt_v = 24;
      end else begin
        up_v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        dn_v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        nt_v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 48);
      end
      write_reg(CFG_UP, {3'($urandom), 5'(up_v)});
      write_reg(CFG_DOWN, {3'($urandom), 5'(dn_v)});
      write_reg(CFG_TAPS, 8'(nt_v));
      if (ph == PRESS_PHASE) hold_pending = 1'b1;
      if ($urandom_range(0, 2) == 0)
        for (int i = 0; i < 16; i++) queue_tap(TAPIDX_W'($urandom), rand_tap());
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
